FILE: rtl/bvm_pkg.sv
// package: types, constants and opcodes for the byte vm instruction core
package bvm_pkg;

   localparam int MEMORY_BYTES = 4096;
   localparam int STACK_DEPTH  = 16;

   localparam logic [11:0] PC_START = 12'h200;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
   localparam logic [7:0]  KEY_DOWN = 8'h9E;
   localparam logic [7:0]  KEY_UP   = 8'hA1;
   localparam logic [7:0]  F_LOAD  = 8'h65;
   localparam logic [7:0]  F_STORE = 8'h55;
   localparam logic [7:0]  F_ADDI  = 8'h1E;
   localparam logic [7:0]  F_BCD   = 8'h33;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] address;
      logic [7:0]  write_data;
      logic [15:0] keys_down;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic [11:0] index_value;
      logic        clear_screen;
      logic        draw_request;
      logic [7:0]  draw_x;
      logic [7:0]  draw_y;
      logic [3:0]  draw_rows;
      logic [7:0]  read_data;
      logic        stack_fault;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_WAIT, ST_FETCH_HI, ST_FETCH_LO, ST_EXEC,
      ST_LOAD, ST_STORE, ST_BCD, ST_RET_WAIT, ST_DONE
   } state_type;

   function automatic logic [11:0] advance_pc(input logic [11:0] p);
      logic [12:0] n;
      n = {1'b0, p} + 13'd2;
      return n[12] ? PC_START : n[11:0];
   endfunction

endpackage

FILE: rtl/bvm_ram.sv
// generic single port ram with registered read
module bvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: rtl/byte_vm_instruction_core.sv
// top level: byte vm interpreter cpu with memory and return stack rams
// writes, reads and executes all go through the single ram port; load and store of n+1 regs
// and bcd move their bytes through it one at a time
// one word in flight at a time; the result register frees the input side unless the result is stalled
// reset: pc 0x200, index and sp 0, data registers 0; memory and stack undefined
module byte_vm_instruction_core #(
   parameter int MEMORY_BYTES = bvm_pkg::MEMORY_BYTES,
   parameter int STACK_DEPTH  = bvm_pkg::STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bvm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bvm_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(MEMORY_BYTES);
   localparam int SW = $clog2(STACK_DEPTH);

   bvm_pkg::state_type state_ff, state_in;
   bvm_pkg::req_type   req_ff;
   logic [11:0] pc_ff, pc_in, idx_ff, idx_in;
   logic [4:0]  sp_ff, sp_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  hi_ff;
   logic [15:0] op;
   logic [3:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff;
   bvm_pkg::rsp_type rsp_ff, rsp_in;

   logic          m_we;
   logic [AW-1:0] m_addr;
   logic [7:0]    m_wdata, m_rdata;
   logic          s_we;
   logic [SW-1:0] s_addr;
   logic [11:0]   s_rdata;

   bvm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
   bvm_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(pc_ff), .rdata(s_rdata));

   assign op = {hi_ff, m_rdata};
   wire [3:0] ox = op[11:8];
   wire [3:0] oy = op[7:4];
   wire [7:0] nn = op[7:0];
   wire [7:0] vx = v_ff[ox];
   wire [7:0] vy = v_ff[oy];
   wire [15:0] bcd_hp = {8'd0, vx} * 16'd41;
   wire [7:0] bcd_h = {4'd0, bcd_hp[15:12]};
   wire [7:0] rem_h = vx - 8'(bcd_h * 8'd100);
   wire [15:0] bcd_tp = {8'd0, rem_h} * 16'd205;
   wire [7:0] bcd_t = {3'd0, bcd_tp[15:11]};
   wire [7:0] bcd_o = rem_h - 8'(bcd_t * 8'd10);
   logic [7:0] bcd_ff [3];

   wire acc = req_valid && !req_stall;
   assign req_stall = (state_ff != bvm_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bvm_pkg::ST_IDLE: begin
            if (acc) begin
               unique case (req_data.command)
                  bvm_pkg::CMD_WRITE: state_in = bvm_pkg::ST_DONE;
                  bvm_pkg::CMD_READ:  state_in = bvm_pkg::ST_RD_WAIT;
                  bvm_pkg::CMD_EXEC:  state_in = bvm_pkg::ST_FETCH_HI;
                  default:            state_in = bvm_pkg::ST_DONE;
               endcase
            end
         end
         bvm_pkg::ST_RD_WAIT:  state_in = bvm_pkg::ST_DONE;
         bvm_pkg::ST_FETCH_HI: state_in = bvm_pkg::ST_FETCH_LO;
         bvm_pkg::ST_FETCH_LO: state_in = bvm_pkg::ST_EXEC;
         bvm_pkg::ST_EXEC: begin
            state_in = bvm_pkg::ST_DONE;
            if (op == bvm_pkg::OP_RET && sp_ff != 5'd0) state_in = bvm_pkg::ST_RET_WAIT;
            if (op[15:12] == 4'hF) begin
               if (nn == bvm_pkg::F_LOAD)  state_in = bvm_pkg::ST_LOAD;
               if (nn == bvm_pkg::F_STORE) state_in = bvm_pkg::ST_STORE;
               if (nn == bvm_pkg::F_BCD)   state_in = bvm_pkg::ST_BCD;
            end
         end
         bvm_pkg::ST_LOAD:  if (cnt_ff == hi_ff[3:0]) state_in = bvm_pkg::ST_DONE;
         bvm_pkg::ST_STORE: if (cnt_ff >= hi_ff[3:0]) state_in = bvm_pkg::ST_DONE;
         bvm_pkg::ST_BCD:   if (cnt_ff == 4'd2) state_in = bvm_pkg::ST_DONE;
         bvm_pkg::ST_RET_WAIT: state_in = bvm_pkg::ST_DONE;
         bvm_pkg::ST_DONE:  state_in = bvm_pkg::ST_IDLE;
         default:           state_in = bvm_pkg::ST_IDLE;
      endcase
   end

   // memory ports and datapath
   logic [3:0] vw_idx, vf_val;
   logic       vw_en, vf_en;
   logic [7:0] vw_val;
   logic       skip;
   logic [8:0] sum;
   logic       down;
   always_comb begin
      m_we = 1'b0;
      m_addr = req_data.address[AW-1:0];
      m_wdata = req_data.write_data;
      s_we = 1'b0;
      s_addr = SW'(sp_ff);
      pc_in = pc_ff;
      idx_in = idx_ff;
      sp_in = sp_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;
      vw_en = 1'b0; vw_idx = ox; vw_val = 8'd0;
      vf_en = 1'b0; vf_val = 4'd0;
      skip = 1'b0;
      sum = 9'd0;
      down = 1'b0;
      unique case (state_ff)
         bvm_pkg::ST_IDLE: begin
            if (acc) begin
               m_we = (req_data.command == bvm_pkg::CMD_WRITE);
               rsp_in = '0;
               rsp_in.program_counter = pc_ff;
               rsp_in.index_value = idx_ff;
               if (req_data.command == bvm_pkg::CMD_EXEC) m_addr = pc_ff[AW-1:0];
            end
         end
         bvm_pkg::ST_RD_WAIT: rsp_in.read_data = m_rdata;
         bvm_pkg::ST_FETCH_HI: m_addr = AW'(pc_ff + 12'd1);
         bvm_pkg::ST_FETCH_LO: begin
            m_addr = AW'(pc_ff + 12'd1);
            pc_in = bvm_pkg::advance_pc(pc_ff);
         end
         bvm_pkg::ST_EXEC: begin
            cnt_in = 4'd0;
            m_addr = idx_ff[AW-1:0];
            unique case (op[15:12])
               4'h0: begin
                  if (op == bvm_pkg::OP_CLS) rsp_in.clear_screen = 1'b1;
                  if (op == bvm_pkg::OP_RET) begin
                     if (sp_ff == 5'd0) rsp_in.stack_fault = 1'b1;
                     else begin
                        sp_in = sp_ff - 5'd1;
                        s_addr = SW'(sp_ff - 5'd1);
                     end
                  end
               end
               4'h1: pc_in = op[11:0];
               4'h2: begin
                  if (sp_ff >= 5'(STACK_DEPTH)) rsp_in.stack_fault = 1'b1;
                  else begin
                     s_we = 1'b1;
                     sp_in = sp_ff + 5'd1;
                     pc_in = op[11:0];
                  end
               end
               4'h3: skip = (vx == nn);
               4'h4: skip = (vx != nn);
               4'h5: skip = (vx == vy);
               4'h6: begin vw_en = 1'b1; vw_val = nn; end
               4'h7: begin vw_en = 1'b1; vw_val = vx + nn; end
               4'h8: begin
                  case (op[3:0])
                     4'h0: begin vw_en = 1'b1; vw_val = vy; end
                     4'h1: begin vw_en = 1'b1; vw_val = vx | vy; end
                     4'h2: begin vw_en = 1'b1; vw_val = vx & vy; end
                     4'h3: begin vw_en = 1'b1; vw_val = vx ^ vy; end
                     4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vw_en = 1'b1; vw_val = sum[7:0];
                        vf_en = 1'b1; vf_val = {3'd0, sum[8]};
                     end
                     4'h5: begin
                        vw_en = 1'b1; vw_val = vx - vy;
                        vf_en = 1'b1; vf_val = {3'd0, vx > vy};
                     end
                     4'h6: begin
                        vw_en = 1'b1; vw_val = vx >> 1;
                        vf_en = 1'b1; vf_val = {3'd0, vx[0]};
                     end
                     4'h7: begin
                        vw_en = 1'b1; vw_val = vy - vx;
                        vf_en = 1'b1; vf_val = {3'd0, vy > vx};
                     end
                     4'hE: begin
                        vw_en = 1'b1; vw_val = vx << 1;
                        vf_en = 1'b1; vf_val = {3'd0, vx[7]};
                     end
                     default: ;
                  endcase
               end
               4'h9: skip = (vx != vy);
               4'hA: idx_in = op[11:0];
               4'hB: pc_in = 12'({4'd0, v_ff[0]} + op[11:0]);
               4'hC: begin vw_en = 1'b1; vw_val = req_ff.random_byte & nn; end
               4'hD: begin
                  vf_en = 1'b1; vf_val = 4'd0;
                  rsp_in.draw_request = 1'b1;
                  rsp_in.draw_x = (ox == 4'hF) ? 8'd0 : vx;
                  rsp_in.draw_y = (oy == 4'hF) ? 8'd0 : vy;
                  rsp_in.draw_rows = op[3:0];
               end
               4'hE: begin
                  down = vx[7:4] == 4'd0 && req_ff.keys_down[vx[3:0]];
                  if (nn == bvm_pkg::KEY_DOWN) skip = down;
                  if (nn == bvm_pkg::KEY_UP) skip = !down;
               end
               default: begin
                  if (nn == bvm_pkg::F_ADDI) idx_in = idx_ff + {4'd0, vx};
                  if (nn == bvm_pkg::F_STORE) begin
                     m_we = 1'b1; m_wdata = v_ff[0];
                     cnt_in = 4'd1;
                  end
                  if (nn == bvm_pkg::F_BCD) begin
                     m_we = 1'b1; m_wdata = bcd_h;
                     cnt_in = 4'd1;
                  end
               end
            endcase
            if (skip) pc_in = bvm_pkg::advance_pc(pc_ff);
         end
         bvm_pkg::ST_LOAD: begin
            m_addr = AW'(idx_ff + {8'd0, cnt_ff} + 12'd1);
            vw_en = 1'b1; vw_idx = cnt_ff; vw_val = m_rdata;
            cnt_in = cnt_ff + 4'd1;
         end
         bvm_pkg::ST_STORE: begin
            m_addr = AW'(idx_ff + {8'd0, cnt_ff});
            m_we = (cnt_ff <= hi_ff[3:0]) && (cnt_ff != 4'd0);
            m_wdata = v_ff[cnt_ff];
            cnt_in = cnt_ff + 4'd1;
         end
         bvm_pkg::ST_BCD: begin
            m_addr = AW'(idx_ff + {8'd0, cnt_ff});
            m_we = (cnt_ff != 4'd0);
            m_wdata = bcd_ff[cnt_ff[1:0]];
            cnt_in = cnt_ff + 4'd1;
         end
         bvm_pkg::ST_RET_WAIT: pc_in = s_rdata;
         bvm_pkg::ST_DONE: begin
            rsp_in.program_counter = pc_ff;
            rsp_in.index_value = idx_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bvm_pkg::ST_IDLE;
         pc_ff <= bvm_pkg::PC_START;
         idx_ff <= 12'd0;
         sp_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) v_ff[i] <= 8'd0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         idx_ff <= idx_in;
         sp_ff <= sp_in;
         // flag wins over the result when both target vf
         if (vw_en && !(vf_en && vw_idx == 4'hF)) v_ff[vw_idx] <= vw_val;
         if (vf_en) v_ff[15] <= {4'd0, vf_val};
         if (state_ff == bvm_pkg::ST_DONE) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cnt_ff <= cnt_in;
      if (acc) req_ff <= req_data;
      if (state_ff == bvm_pkg::ST_FETCH_HI) hi_ff <= m_rdata;
      if (state_ff == bvm_pkg::ST_EXEC) begin
         hi_ff <= op[15:8];
         bcd_ff[0] <= bcd_h;
         bcd_ff[1] <= bcd_t;
         bcd_ff[2] <= bcd_o;
      end
   end

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != bvm_pkg::ST_IDLE |-> req_stall)
      else $error("input taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= 5'(STACK_DEPTH))
      else $error("stack pointer out of range");
endmodule

FILE: tb/byte_vm_instruction_core_checker.sv
// checker: predicts every response of the byte vm core and compares it field by field
module byte_vm_instruction_core_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bvm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bvm_pkg::rsp_type rsp_data,
   output int               errors,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] GRP_SYS = 4'h0, GRP_JMP = 4'h1, GRP_CALL = 4'h2, GRP_SEQI = 4'h3,
                          GRP_SNEI = 4'h4, GRP_SEQR = 4'h5, GRP_LDI = 4'h6, GRP_ADDI = 4'h7,
                          GRP_ALU = 4'h8, GRP_SNER = 4'h9, GRP_LDIDX = 4'hA, GRP_JMPV0 = 4'hB,
                          GRP_RAND = 4'hC, GRP_DRAW = 4'hD, GRP_KEY = 4'hE, GRP_MISC = 4'hF;
   localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
                          ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
                          ALU_SHL = 4'hE;

   logic [7:0]  mem [bvm_pkg::MEMORY_BYTES];
   logic [7:0]  vreg [16];
   logic [11:0] stk [16];
   logic [4:0]  sp;
   logic [11:0] pc;
   logic [11:0] idx;
   bvm_pkg::rsp_type expected_rsps [$];

   function automatic logic [11:0] pc_plus2(input logic [11:0] p);
      return (p >= 12'hFFE) ? bvm_pkg::PC_START : p + 12'd2;
   endfunction

   function automatic bvm_pkg::rsp_type execute_word(input bvm_pkg::req_type r);
      bvm_pkg::rsp_type e;
      logic [15:0] op;
      logic [3:0]  x, y;
      logic [7:0]  nn, vx, vy;
      logic [8:0]  s;
      logic [11:0] at;
      logic        skip, down;
      e = '0;
      skip = 1'b0;
      if (r.command == bvm_pkg::CMD_WRITE) begin
         mem[r.address] = r.write_data;
      end else if (r.command == bvm_pkg::CMD_READ) begin
         e.read_data = mem[r.address];
      end else if (r.command == bvm_pkg::CMD_EXEC) begin
         at = pc;
         op = {mem[at], mem[at + 12'd1]};
         x = op[11:8];
         y = op[7:4];
         nn = op[7:0];
         vx = vreg[x];
         vy = vreg[y];
         pc = pc_plus2(at);
         case (op[15:12])
            GRP_SYS: begin
               if (op == bvm_pkg::OP_CLS) begin
                  e.clear_screen = 1'b1;
               end else if (op == bvm_pkg::OP_RET) begin
                  if (sp == 0) begin
                     e.stack_fault = 1'b1;
                  end else begin
                     sp = sp - 5'd1;
                     pc = stk[sp[3:0]];
                  end
               end
            end
            GRP_JMP: pc = op[11:0];
            GRP_CALL: begin
               if (sp >= bvm_pkg::STACK_DEPTH) begin
                  e.stack_fault = 1'b1;
               end else begin
                  stk[sp[3:0]] = pc;
                  sp = sp + 5'd1;
                  pc = op[11:0];
               end
            end
            GRP_SEQI: skip = (vx == nn);
            GRP_SNEI: skip = (vx != nn);
            GRP_SEQR: skip = (vx == vy);
            GRP_LDI: vreg[x] = nn;
            GRP_ADDI: vreg[x] = vx + nn;
            GRP_ALU: begin
               case (op[3:0])
                  ALU_MOV: vreg[x] = vy;
                  ALU_OR:  vreg[x] = vx | vy;
                  ALU_AND: vreg[x] = vx & vy;
                  ALU_XOR: vreg[x] = vx ^ vy;
                  ALU_ADD: begin
                     s = {1'b0, vx} + {1'b0, vy};
                     vreg[x] = s[7:0];
                     vreg[15] = {7'd0, s[8]};
                  end
                  ALU_SUB: begin
                     vreg[x] = vx - vy;
                     vreg[15] = {7'd0, vx > vy};
                  end
                  ALU_SHR: begin
                     vreg[x] = vx >> 1;
                     vreg[15] = {7'd0, vx[0]};
                  end
                  ALU_SUBN: begin
                     vreg[x] = vy - vx;
                     vreg[15] = {7'd0, vy > vx};
                  end
                  ALU_SHL: begin
                     vreg[x] = vx << 1;
                     vreg[15] = {7'd0, vx[7]};
                  end
                  default: ;
               endcase
            end
            GRP_SNER: skip = (vx != vy);
            GRP_LDIDX: idx = op[11:0];
            GRP_JMPV0: pc = {4'd0, vreg[0]} + op[11:0];
            GRP_RAND: vreg[x] = r.random_byte & nn;
            GRP_DRAW: begin
               vreg[15] = 8'd0;
               e.draw_request = 1'b1;
               e.draw_x = vreg[x];
               e.draw_y = vreg[y];
               e.draw_rows = op[3:0];
            end
            GRP_KEY: begin
               down = (vx < 8'd16) && r.keys_down[vx[3:0]];
               if (nn == bvm_pkg::KEY_DOWN) skip = down;
               else if (nn == bvm_pkg::KEY_UP) skip = !down;
            end
            GRP_MISC: begin
               case (nn)
                  bvm_pkg::F_LOAD:
                     for (int k = 0; k <= x; k++) vreg[k] = mem[idx + 12'(k)];
                  bvm_pkg::F_STORE:
                     for (int k = 0; k <= x; k++) mem[idx + 12'(k)] = vreg[k];
                  bvm_pkg::F_ADDI: idx = idx + {4'd0, vx};
                  bvm_pkg::F_BCD: begin
                     mem[idx] = vx / 8'd100;
                     mem[idx + 12'd1] = (vx % 8'd100) / 8'd10;
                     mem[idx + 12'd2] = vx % 8'd10;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         if (skip) pc = pc_plus2(pc);
      end
      e.program_counter = pc;
      e.index_value = idx;
      return e;
   endfunction

   assign pending = expected_rsps.size();

   always @(posedge clock) begin
      bvm_pkg::rsp_type e;
      if (reset) begin
         for (int k = 0; k < 16; k++) vreg[k] = 8'd0;
         sp = 5'd0;
         pc = bvm_pkg::PC_START;
         idx = 12'd0;
         expected_rsps.delete();
         errors <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response word with nothing expected");
               errors <= errors + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (e != rsp_data) errors <= errors + 1;
               if (e.program_counter != rsp_data.program_counter)
                  $error("program_counter exp %h got %h", e.program_counter,
                         rsp_data.program_counter);
               if (e.index_value != rsp_data.index_value)
                  $error("index_value exp %h got %h", e.index_value, rsp_data.index_value);
               if (e.clear_screen != rsp_data.clear_screen)
                  $error("clear_screen exp %b got %b", e.clear_screen, rsp_data.clear_screen);
               if (e.draw_request != rsp_data.draw_request)
                  $error("draw_request exp %b got %b", e.draw_request, rsp_data.draw_request);
               if (e.draw_x != rsp_data.draw_x)
                  $error("draw_x exp %h got %h", e.draw_x, rsp_data.draw_x);
               if (e.draw_y != rsp_data.draw_y)
                  $error("draw_y exp %h got %h", e.draw_y, rsp_data.draw_y);
               if (e.draw_rows != rsp_data.draw_rows)
                  $error("draw_rows exp %h got %h", e.draw_rows, rsp_data.draw_rows);
               if (e.read_data != rsp_data.read_data)
                  $error("read_data exp %h got %h", e.read_data, rsp_data.read_data);
               if (e.stack_fault != rsp_data.stack_fault)
                  $error("stack_fault exp %b got %b", e.stack_fault, rsp_data.stack_fault);
            end
         end
         if (req_valid && !req_stall) expected_rsps.push_back(execute_word(req_data));
      end
   end

endmodule

FILE: tb/byte_vm_instruction_core_tb.sv
// testbench top: clock, reset, stimulus for the byte vm core and the final verdict
module byte_vm_instruction_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_NONE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   bvm_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   bvm_pkg::rsp_type rsp_data;
   int      errors, pending;
   int      words_sent = 0, words_got = 0, items = 0;
   logic [11:0] cur_pc = bvm_pkg::PC_START;
   logic [11:0] cur_idx = 12'd0;
   bit      wr_seen [bvm_pkg::MEMORY_BYTES];
   logic    no_idle = 1'b0;
   logic    long_hold = 1'b0;

   always #4 clock = ~clock;

   byte_vm_instruction_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   byte_vm_instruction_core_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .errors, .pending
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_got <= words_got + 1;
         cur_pc <= rsp_data.program_counter;
         cur_idx <= rsp_data.index_value;
      end
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 27);
            @(posedge clock);
         end
      end
   end

   function automatic bvm_pkg::req_type make_word(input logic [1:0] cmd,
                                                  input logic [11:0] addr,
                                                  input logic [7:0] data);
      bvm_pkg::req_type w;
      w.command = cmd;
      w.address = addr;
      w.write_data = data;
      w.keys_down = 16'($urandom);
      w.random_byte = 8'($urandom);
      return w;
   endfunction

   task automatic send_word(input bvm_pkg::req_type w);
      if (!no_idle && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      if (w.command == bvm_pkg::CMD_WRITE) wr_seen[w.address] = 1'b1;
      words_sent++;
      items++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (words_got != words_sent);
      @(posedge clock);
   endtask

   // places one instruction at the current pc and runs it
   task automatic run_op(input logic [15:0] op, input logic [15:0] keys);
      bvm_pkg::req_type w;
      drain();
      if (op[15:12] == 4'hF && op[7:0] == bvm_pkg::F_LOAD) begin
         for (int k = 0; k <= int'(op[11:8]); k++)
            send_word(make_word(bvm_pkg::CMD_WRITE, cur_idx + 12'(k), 8'($urandom)));
      end
      send_word(make_word(bvm_pkg::CMD_WRITE, cur_pc, op[15:8]));
      send_word(make_word(bvm_pkg::CMD_WRITE, cur_pc + 12'd1, op[7:0]));
      w = make_word(bvm_pkg::CMD_EXEC, 12'($urandom), 8'($urandom));
      w.keys_down = keys;
      send_word(w);
   endtask

   function automatic logic [15:0] random_op;
      logic [15:0] op;
      op = 16'($urandom);
      case (op[15:12])
         4'h0: op = ($urandom_range(2) == 0) ? bvm_pkg::OP_CLS :
                    ($urandom_range(1) ? bvm_pkg::OP_RET : op);
         4'hE: op[7:0] = ($urandom_range(2) == 0) ? bvm_pkg::KEY_DOWN :
                         ($urandom_range(1) ? bvm_pkg::KEY_UP : op[7:0]);
         4'hF: case ($urandom_range(4))
                  0: op[7:0] = bvm_pkg::F_LOAD;
                  1: op[7:0] = bvm_pkg::F_STORE;
                  2: op[7:0] = bvm_pkg::F_ADDI;
                  3: op[7:0] = bvm_pkg::F_BCD;
                  default: ;
               endcase
         default: ;
      endcase
      return op;
   endfunction

   task automatic random_word;
      logic [1:0]  cmd;
      logic [11:0] addr;
      cmd = 2'($urandom_range(3));
      addr = 12'($urandom);
      if (cmd == bvm_pkg::CMD_EXEC) cmd = bvm_pkg::CMD_READ;
      if (cmd == bvm_pkg::CMD_READ && !wr_seen[addr]) cmd = bvm_pkg::CMD_WRITE;
      send_word(make_word(cmd, addr, 8'($urandom)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(make_word(bvm_pkg::CMD_WRITE, 12'h000, 8'h00));
      send_word(make_word(bvm_pkg::CMD_WRITE, 12'hFFF, 8'hFF));
      send_word(make_word(bvm_pkg::CMD_READ, 12'h000, 8'h00));
      send_word(make_word(bvm_pkg::CMD_READ, 12'hFFF, 8'hFF));
      send_word(make_word(CMD_NONE, 12'hFFF, 8'hFF));
      run_op(bvm_pkg::OP_RET, 16'h0000);
      run_op(bvm_pkg::OP_CLS, 16'hFFFF);
      run_op(16'h0123, 16'h0000);
      run_op(16'h60FF, 16'h0000);
      run_op(16'h6101, 16'h0000);
      run_op(16'h8014, 16'h0000);
      run_op(16'h8015, 16'h0000);
      run_op(16'h8017, 16'h0000);
      run_op(16'h8016, 16'h0000);
      run_op(16'h801E, 16'h0000);
      run_op(16'h8F04, 16'h0000);
      run_op(16'h8018, 16'h0000);
      run_op(16'hDF1F, 16'h0000);
      run_op(16'h6503, 16'h0000);
      run_op(16'hE59E, 16'h0008);
      run_op(16'hE5A1, 16'h0008);
      run_op(16'h6520, 16'h0000);
      run_op(16'hE59E, 16'hFFFF);
      run_op(16'hE5A1, 16'hFFFF);
      run_op(16'h30FF, 16'h0000);
      run_op(16'h4000, 16'h0000);
      run_op(16'h5010, 16'h0000);
      run_op(16'h9010, 16'h0000);
      run_op(16'hC0AA, 16'h0000);
      run_op(16'h60FE, 16'h0000);
      run_op(16'hAFFE, 16'h0000);
      run_op(16'hF033, 16'h0000);
      run_op(16'hFF55, 16'h0000);
      run_op(16'hFF65, 16'h0000);
      run_op(16'hF01E, 16'h0000);
      run_op(16'hF0FF, 16'h0000);
      run_op(16'hBFFF, 16'h0000);
      for (int k = 0; k < 17; k++)
         run_op({4'h2, 12'($urandom_range(12'h200, 12'hFF0))}, 16'h0000);
      for (int k = 0; k < 17; k++) run_op(bvm_pkg::OP_RET, 16'h0000);
      run_op(16'h1FFE, 16'h0000);
      run_op(16'h6000, 16'h0000);
      run_op(16'h1FFF, 16'h0000);
      run_op(16'h6000, 16'h0000);

      // receiver holds off while words keep coming
      drain();
      long_hold = 1'b1;
      for (int k = 0; k < 20; k++) random_word();

      items = 0;
      while (items < 400) begin
         no_idle = (items < 150);
         if ($urandom_range(9) < 6) run_op(random_op(), 16'($urandom));
         else random_word();
      end
      no_idle = 1'b0;
      drain();
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("byte_vm_instruction_core regression: pass");
      end else begin
         $display("byte_vm_instruction_core regression: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("byte_vm_instruction_core regression: fail");
      $finish;
   end

endmodule
